FILE: rtl/sett_pkg.sv
// Shared package for the sorted event timeline table.
// Holds defaults, operation and status codes, and the queued command word.
// No dependencies.
package sett_pkg;

    localparam int DEF_MAX_EVENTS = 64;
    localparam int DEF_MAX_IDS    = 16;
    localparam int DEF_MAX_FRAMES = 4096;
    localparam int DEF_MAX_POINTS = 32;

    localparam logic [1:0] F_INSERT  = 2'd0;
    localparam logic [1:0] F_ERASE   = 2'd1;
    localparam logic [1:0] F_CLEAR   = 2'd2;
    localparam logic [1:0] F_COLLECT = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_REJ   = 2'd1;
    localparam logic [1:0] ST_POINT = 2'd2;

    localparam logic [16:0] Q_ONE = 17'd65536;

    // table entry: position, id, value
    localparam int ENTRY_W = 64 + 32 + 17;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] key;      // insert position or block start
        logic [31:0] id;
        logic [16:0] val;
        logic [5:0]  idx;
        logic [63:0] end_pos;  // block end for collect
        logic        bad;      // precomputed refusal
    } t_cmd;

endpackage

FILE: rtl/sett_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sett_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sett_front.sv
// Front end: accepts input words, flags refusals that need no table state,
// and queues them for the back end. Depends on sett_pkg.
module sett_front #(
    parameter int MAX_FRAMES = sett_pkg::DEF_MAX_FRAMES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic [63:0]         i_sample_position,
    input  logic [31:0]         i_parameter_id,
    input  logic [16:0]         i_norm_value,
    input  logic [5:0]          i_entry_index,
    input  logic [63:0]         i_block_start,
    input  logic [15:0]         i_frame_count,
    input  logic                i_pop,
    output logic                o_cmd_valid,
    output sett_pkg::t_cmd      o_cmd
);
    import sett_pkg::*;

    t_cmd        r_q [2];
    logic [1:0]  r_cnt, n_cnt;
    logic        r_wp, r_rp;
    logic        push, pop;
    t_cmd        w_cmd;
    logic [64:0] sum;

    assign sum = {1'b0, i_block_start} + 65'(i_frame_count);

    always_comb begin
        w_cmd.func    = i_func;
        w_cmd.key     = (i_func == F_COLLECT) ? i_block_start : i_sample_position;
        w_cmd.id      = i_parameter_id;
        w_cmd.val     = i_norm_value;
        w_cmd.idx     = i_entry_index;
        w_cmd.end_pos = sum[63:0];
        case (i_func)
            F_INSERT:  w_cmd.bad = (i_norm_value > Q_ONE);
            F_COLLECT: w_cmd.bad = (i_frame_count == 16'd0)
                                || ({1'b0, i_frame_count} > 17'(MAX_FRAMES))
                                || sum[64];
            default:   w_cmd.bad = 1'b0;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign pop         = i_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule

FILE: rtl/sett_back.sv
// Back end: runs queued commands against the sorted table RAM and an id
// reference-count array, and drives the registered result word.
// Depends on sett_pkg and sett_ram.
module sett_back #(
    parameter int MAX_EVENTS = sett_pkg::DEF_MAX_EVENTS,
    parameter int MAX_IDS    = sett_pkg::DEF_MAX_IDS,
    parameter int MAX_POINTS = sett_pkg::DEF_MAX_POINTS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  sett_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_status,
    output logic [31:0]     o_point_parameter,
    output logic [11:0]     o_point_offset,
    output logic [16:0]     o_point_value,
    output logic            o_last
);
    import sett_pkg::*;

    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int AW = $clog2(MAX_EVENTS);
    localparam int IW = (CW > 6) ? CW : 6;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_RESP    = 15'b000000000000010,
        S_INS_CHK = 15'b000000000000100,
        S_INS_RD  = 15'b000000000001000,
        S_INS_EV  = 15'b000000000010000,
        S_INS_WR  = 15'b000000000100000,
        S_ERS_RD0 = 15'b000000001000000,
        S_ERS_ID  = 15'b000000010000000,
        S_ERS_RD  = 15'b000000100000000,
        S_ERS_EV  = 15'b000001000000000,
        S_CNT_RD  = 15'b000010000000000,
        S_CNT_EV  = 15'b000100000000000,
        S_CNT_END = 15'b001000000000000,
        S_EMIT_RD = 15'b010000000000000,
        S_EMIT_EV = 15'b100000000000000
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [CW-1:0]   r_total, n_total;
    logic [CW-1:0]   r_at, n_at;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_k, n_k;
    logic [1:0]      r_resp, n_resp;
    logic [CW-1:0]   at_m1, at_p1;

    logic [31:0]     r_cam_id  [MAX_IDS];
    logic [31:0]     n_cam_id  [MAX_IDS];
    logic [CW-1:0]   r_cam_cnt [MAX_IDS];
    logic [CW-1:0]   n_cam_cnt [MAX_IDS];
    logic [MAX_IDS-1:0] match, free1h;
    logic            hit, any_free;
    logic [31:0]     cam_key;

    logic            r_ov, n_ov;
    logic [1:0]      r_o_status, n_o_status;
    logic [31:0]     r_o_par, n_o_par;
    logic [11:0]     r_o_off, n_o_off;
    logic [16:0]     r_o_val, n_o_val;
    logic            r_o_last, n_o_last;
    logic            out_free;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [63:0]     rd_pos;
    logic [31:0]     rd_id;
    logic [16:0]     rd_val;
    logic            in_range, new_less;

    sett_ram #(.W(ENTRY_W), .D(MAX_EVENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign {rd_pos, rd_id, rd_val} = rdata;
    assign at_m1    = r_at - 1'b1;
    assign at_p1    = r_at + 1'b1;
    assign raddr    = (r_state == S_INS_RD) ? at_m1[AW-1:0] : r_at[AW-1:0];
    assign in_range = (rd_pos >= r_cmd.key) && (rd_pos < r_cmd.end_pos);
    assign new_less = (r_cmd.key < rd_pos)
                   || ((r_cmd.key == rd_pos) && (r_cmd.id < rd_id));
    assign out_free = !r_ov || !i_stall;
    assign cam_key  = (r_state == S_ERS_ID) ? rd_id : r_cmd.id;

    // id slots: live when count is nonzero
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int s = 0; s < MAX_IDS; s++) begin
            match[s]  = (r_cam_cnt[s] != '0) && (r_cam_id[s] == cam_key);
            free1h[s] = (r_cam_cnt[s] == '0) && !seen;
            seen      = seen || (r_cam_cnt[s] == '0);
        end
        any_free = seen;
        hit      = |match;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_total    = r_total;
        n_at       = r_at;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_resp     = r_resp;
        n_cam_id   = r_cam_id;
        n_cam_cnt  = r_cam_cnt;
        n_ov       = r_ov && i_stall;
        n_o_status = r_o_status;
        n_o_par    = r_o_par;
        n_o_off    = r_o_off;
        n_o_val    = r_o_val;
        n_o_last   = r_o_last;
        o_pop      = 1'b0;
        we         = 1'b0;
        waddr      = r_at[AW-1:0];
        wdata      = rdata;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.func)
                        F_INSERT: begin
                            if (i_cmd.bad || (r_total == CW'(MAX_EVENTS))) begin
                                n_resp  = ST_REJ;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_INS_CHK;
                            end
                        end
                        F_ERASE: begin
                            if (IW'(i_cmd.idx) >= IW'(r_total)) begin
                                n_resp  = ST_REJ;
                                n_state = S_RESP;
                            end else begin
                                n_at    = CW'(i_cmd.idx);
                                n_state = S_ERS_RD0;
                            end
                        end
                        F_CLEAR: begin
                            n_total = '0;
                            for (int s = 0; s < MAX_IDS; s++) begin
                                n_cam_cnt[s] = '0;
                            end
                            n_resp  = ST_OK;
                            n_state = S_RESP;
                        end
                        F_COLLECT: begin
                            n_at  = '0;
                            n_cnt = '0;
                            if (i_cmd.bad) begin
                                n_resp  = ST_REJ;
                                n_state = S_RESP;
                            end else if (r_total == '0) begin
                                n_resp  = ST_OK;
                                n_state = S_RESP;
                            end else begin
                                n_state = S_CNT_RD;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_resp;
                    n_o_par    = '0;
                    n_o_off    = '0;
                    n_o_val    = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_INS_CHK: begin
                if (!hit && !any_free) begin
                    n_resp  = ST_REJ;
                    n_state = S_RESP;
                end else begin
                    for (int s = 0; s < MAX_IDS; s++) begin
                        if (match[s]) begin
                            n_cam_cnt[s] = r_cam_cnt[s] + 1'b1;
                        end else if (!hit && free1h[s]) begin
                            n_cam_cnt[s] = CW'(1);
                            n_cam_id[s]  = r_cmd.id;
                        end
                    end
                    n_at    = r_total;
                    n_state = (r_total == '0) ? S_INS_WR : S_INS_RD;
                end
            end
            S_INS_RD: n_state = S_INS_EV;
            S_INS_EV: begin
                if (new_less) begin
                    we      = 1'b1;
                    n_at    = at_m1;
                    n_state = (at_m1 == '0) ? S_INS_WR : S_INS_RD;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                we      = 1'b1;
                wdata   = {r_cmd.key, r_cmd.id, r_cmd.val};
                n_total = r_total + 1'b1;
                n_resp  = ST_OK;
                n_state = S_RESP;
            end
            S_ERS_RD0: n_state = S_ERS_ID;
            S_ERS_ID: begin
                for (int s = 0; s < MAX_IDS; s++) begin
                    if (match[s]) begin
                        n_cam_cnt[s] = r_cam_cnt[s] - 1'b1;
                    end
                end
                if (at_p1 == r_total) begin
                    n_total = r_total - 1'b1;
                    n_resp  = ST_OK;
                    n_state = S_RESP;
                end else begin
                    n_at    = at_p1;
                    n_state = S_ERS_RD;
                end
            end
            S_ERS_RD: n_state = S_ERS_EV;
            S_ERS_EV: begin
                we    = 1'b1;
                waddr = at_m1[AW-1:0];
                if (at_p1 == r_total) begin
                    n_total = r_total - 1'b1;
                    n_resp  = ST_OK;
                    n_state = S_RESP;
                end else begin
                    n_at    = at_p1;
                    n_state = S_ERS_RD;
                end
            end
            S_CNT_RD: n_state = S_CNT_EV;
            S_CNT_EV: begin
                if (in_range) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (at_p1 == r_total) begin
                    n_state = S_CNT_END;
                end else begin
                    n_at    = at_p1;
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_END: begin
                if (32'(r_cnt) > 32'(MAX_POINTS)) begin
                    n_resp  = ST_REJ;
                    n_state = S_RESP;
                end else if (r_cnt == '0) begin
                    n_resp  = ST_OK;
                    n_state = S_RESP;
                end else begin
                    n_at    = '0;
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_EV;
            S_EMIT_EV: begin
                if (!in_range) begin
                    n_at    = at_p1;
                    n_state = S_EMIT_RD;
                end else if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = ST_POINT;
                    n_o_par    = rd_id;
                    n_o_off    = rd_pos[11:0] - r_cmd.key[11:0];
                    n_o_val    = rd_val;
                    n_o_last   = (r_k + 1'b1 == r_cnt);
                    n_k        = r_k + 1'b1;
                    if (r_k + 1'b1 == r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_at    = at_p1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_ov      <= 1'b0;
            r_cam_cnt <= '{default: '0};
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_ov      <= n_ov;
            r_cam_cnt <= n_cam_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_at       <= n_at;
        r_cnt      <= n_cnt;
        r_k        <= n_k;
        r_resp     <= n_resp;
        r_cam_id   <= n_cam_id;
        r_o_status <= n_o_status;
        r_o_par    <= n_o_par;
        r_o_off    <= n_o_off;
        r_o_val    <= n_o_val;
        r_o_last   <= n_o_last;
    end

    assign o_valid           = r_ov;
    assign o_status          = r_o_status;
    assign o_point_parameter = r_o_par;
    assign o_point_offset    = r_o_off;
    assign o_point_value     = r_o_val;
    assign o_last            = r_o_last;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(MAX_EVENTS))
        else $error("entry count above table size");

    a_id_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("id held in more than one slot");

    a_point_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_status == ST_POINT)) |-> (r_o_val <= Q_ONE))
        else $error("collected value above 1.0");

    a_point_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_EV) |-> (r_k < r_cnt))
        else $error("emitted more points than counted");
endmodule

FILE: rtl/sorted_event_timeline_table.sv
// Sorted event timeline table: top level.
// Input channel: i_valid / o_stall, one word per accepted edge with i_func
// selecting insert, erase, clear or collect. Output channel: o_valid /
// i_stall, result words with o_status, point fields and o_last.
// Every input word gives one result word, except a collect that finds
// points, which gives one word per point in table order (o_last on the
// final one).
// A two-word queue parts the front end from the back end, so new words are
// taken while the back end works or a result waits.
// Work per word depends on the table (n = entries held): clear and early
// refusals go straight to the result; insert takes an id slot or counts
// up its id, reads back from the end and moves each later entry up one
// place, then writes the new entry; erase frees the id, then moves each
// later entry down one place; collect reads all n entries to count the
// points in the block, then scans again from index 0 to emit them.
// The bound is the table RAM, read one entry at a time with a read state
// and an evaluate state per entry, so a collect is the slowest word.
// Reset (synchronous, i_rst_n low) empties the table and the queue; no
// clearing pass is needed. A stalled result holds its word and the back end
// waits; the queue keeps accepting until it holds two words.
// Depends on sett_pkg, sett_front, sett_back, sett_ram.
module sorted_event_timeline_table #(
    parameter int MAX_EVENTS = sett_pkg::DEF_MAX_EVENTS,
    parameter int MAX_IDS    = sett_pkg::DEF_MAX_IDS,
    parameter int MAX_FRAMES = sett_pkg::DEF_MAX_FRAMES,
    parameter int MAX_POINTS = sett_pkg::DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_sample_position,
    input  logic [31:0] i_parameter_id,
    input  logic [16:0] i_norm_value,
    input  logic [5:0]  i_entry_index,
    input  logic [63:0] i_block_start,
    input  logic [15:0] i_frame_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_point_parameter,
    output logic [11:0] o_point_offset,
    output logic [16:0] o_point_value,
    output logic        o_last
);
    import sett_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic pop;

    sett_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_sample_position (i_sample_position),
        .i_parameter_id    (i_parameter_id),
        .i_norm_value      (i_norm_value),
        .i_entry_index     (i_entry_index),
        .i_block_start     (i_block_start),
        .i_frame_count     (i_frame_count),
        .i_pop             (pop),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd)
    );

    sett_back #(
        .MAX_EVENTS (MAX_EVENTS),
        .MAX_IDS    (MAX_IDS),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_point_parameter (o_point_parameter),
        .o_point_offset    (o_point_offset),
        .o_point_value     (o_point_value),
        .o_last            (o_last)
    );
endmodule
